>>> rtl/qtt_pkg.sv
// query text tokenizer package: token kinds, lexer modes, keyword table
// no dependencies
`default_nettype none
package qtt_pkg;
  localparam int LineWidthDef = 16;
  localparam int OffsetWidthDef = 32;
  localparam int KeywordCountDef = 26;
  localparam int KwMaxLen = 17;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0, M_STR = 3'd1, M_INT = 3'd2, M_WORD = 3'd3, M_GT = 3'd4, M_LT = 3'd5
  } mode_t;

  localparam logic [5:0] K_STRING = 6'd26;
  localparam logic [5:0] K_INT = 6'd27;
  localparam logic [5:0] K_STAR = 6'd28;
  localparam logic [5:0] K_DOT = 6'd29;
  localparam logic [5:0] K_COMMA = 6'd30;
  localparam logic [5:0] K_LPAR = 6'd31;
  localparam logic [5:0] K_RPAR = 6'd32;
  localparam logic [5:0] K_GE = 6'd33;
  localparam logic [5:0] K_LE = 6'd34;
  localparam logic [5:0] K_GT = 6'd35;
  localparam logic [5:0] K_LT = 6'd36;
  localparam logic [5:0] K_EQ = 6'd37;
  localparam logic [5:0] K_END = 6'd38;
  localparam logic [5:0] K_UNK = 6'd39;

  // lower-case keyword text, padded with zero bytes
  function automatic logic [7:0] kw_char(input int k, input int p);
    string s;
    case (k)
      0: s = "select";          1: s = "subscribe";       2: s = "from";
      3: s = "where";           4: s = "limit";           5: s = "and";
      6: s = "between";         7: s = "at";              8: s = "sum";
      9: s = "avg";             10: s = "min";            11: s = "max";
      12: s = "vwap";           13: s = "spread";
      14: begin
        s = "mid";
        s = {s, "_price"};
      end
      15: s = "imbalance";
      16: begin
        s = "depth";
        s = {s, "_range"};
      end
      17: s = "depth";
      18: begin
        s = "cumulative";
        s = {s, "_volume"};
      end
      19: s = "price";          20: s = "quantity";
      21: begin
        s = "order";
        s = {s, "_count"};
      end
      22: s = "timestamp";
      23: begin
        s = "sequence";
        s = {s, "_number"};
      end
      24: s = "side";           default: s = "level";
    endcase
    if (p < s.len()) return s[p];
    return 8'd0;
  endfunction

  function automatic logic [4:0] kw_len(input int k);
    int n;
    n = 0;
    for (int p = 0; p < KwMaxLen; p++) if (kw_char(k, p) != 8'd0) n = p + 1;
    return 5'(n);
  endfunction
endpackage
`default_nettype wire

>>> rtl/qtt_kw_match.sv
// keyword matcher: per-position mask update and word kind lookup
// depends on qtt_pkg
`default_nettype none
module qtt_kw_match #(
  parameter int KEYWORD_COUNT = qtt_pkg::KeywordCountDef
) (
  input  wire logic [KEYWORD_COUNT-1:0] mask_in,
  input  wire logic [15:0]              pos,
  input  wire logic [7:0]               lc_byte,
  input  wire logic [15:0]              word_len,
  input  wire logic [15:0]              next_len,
  output logic [KEYWORD_COUNT-1:0]      mask_out,
  output logic [5:0]                    kind,
  output logic [5:0]                    next_kind
);
  import qtt_pkg::*;

  function automatic logic [5:0] lookup(input logic [KEYWORD_COUNT-1:0] m,
                                        input logic [15:0] n);
    logic [5:0] r;
    r = K_UNK;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
      if (m[k] && n == 16'(kw_len(k))) r = 6'(k);
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      mask_out[k] = 1'b0;
      for (int p = 0; p < KwMaxLen; p++)
        if (pos == 16'(p) && p < int'(kw_len(k)) && kw_char(k, p) == lc_byte)
          mask_out[k] = mask_in[k];
    end
  end

  // kind of the word so far, and of the word extended by this byte
  assign kind = lookup(mask_in, word_len);
  assign next_kind = lookup(mask_out, next_len);
endmodule
`default_nettype wire

>>> rtl/query_text_tokenizer_top.sv
// query text tokenizer top: lexer state, result queue and output handshake
// depends on qtt_pkg and qtt_kw_match
//
// channel | ports                                                     | dir
// in      | in_valid in_ready in_char_byte in_char_valid in_text_end  | in
// out     | out_valid out_ready out_token_kind ... out_final_token     | out
//
// one byte per cycle while in_ready is high; an item is registered on its
// transfer and lexed, its tokens written to the result fifo, once that fifo has room
// one item yields up to three tokens, queued in a four-entry result fifo that
// drains one token per cycle while out_ready is high
// in_ready drops while the registered item's tokens do not fit in the fifo
// synchronous active-low reset returns to line 1, column 1, offset 0
`default_nettype none
module query_text_tokenizer_top #(
  parameter int LINE_WIDTH = qtt_pkg::LineWidthDef,
  parameter int OFFSET_WIDTH = qtt_pkg::OffsetWidthDef,
  parameter int KEYWORD_COUNT = qtt_pkg::KeywordCountDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_char_valid,
  input  wire logic        in_text_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_start_line,
  output logic [15:0]      out_start_column,
  output logic [31:0]      out_text_offset,
  output logic [15:0]      out_text_length,
  output logic             out_final_token
);
  import qtt_pkg::*;

  localparam int LW = LINE_WIDTH;
  localparam int OW = OFFSET_WIDTH;
  localparam logic [LW-1:0] LMAX = '1;
  localparam logic [OW-1:0] OMAX = '1;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] ln;
    logic [15:0] col;
    logic [31:0] off;
    logic [15:0] len;
    logic        fin;
  } tok_t;

  mode_t mode_r, mode_nxt;
  logic [LW-1:0] line_r, line_nxt, col_r, col_nxt, sline_r, sline_nxt, scol_r, scol_nxt;
  logic [OW-1:0] off_r, off_nxt, sstart_r, sstart_nxt;
  logic [15:0] len_r, len_nxt;
  logic [KEYWORD_COUNT-1:0] mask_r, mask_nxt;

  // input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       icv_r, ie_r;

  tok_t fifo_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;

  tok_t t0, t1, t2;
  logic [1:0] nres;

  // keyword matcher inputs and outputs
  logic [KEYWORD_COUNT-1:0] km_in, km_out;
  logic [15:0] km_pos, km_nlen;
  logic [5:0]  km_kind, km_nkind, wkind, end_wkind;
  logic [7:0]  lc;

  assign lc = (ib_r >= 8'h41 && ib_r <= 8'h5a) ? ib_r + 8'd32 : ib_r;

  // inside a word the byte extends it, otherwise a word can only start here
  assign km_in = (mode_r == M_WORD) ? mask_r : '1;
  assign km_pos = (mode_r == M_WORD) ? len_r : 16'd0;
  assign km_nlen = (mode_r != M_WORD) ? 16'd1 :
                   (len_r == 16'hffff) ? len_r : len_r + 16'd1;

  qtt_kw_match #(.KEYWORD_COUNT(KEYWORD_COUNT)) u_kw (
    .mask_in(km_in), .pos(km_pos), .lc_byte(lc), .word_len(len_r), .next_len(km_nlen),
    .mask_out(km_out), .kind(km_kind), .next_kind(km_nkind)
  );
  assign wkind = km_kind;
  assign end_wkind = icv_r ? km_nkind : km_kind;

  wire pop = out_valid && out_ready;
  wire [2:0] avail = 3'd4 - cnt_r + {2'b0, pop};
  // process the registered item when there is room
  wire go = iv_r && (avail >= {1'b0, nres});
  assign in_ready = (!iv_r) || go;
  wire take = in_valid && in_ready;

  function automatic tok_t mk(input logic [5:0] k, input logic [LW-1:0] l,
                              input logic [LW-1:0] c, input logic [OW-1:0] o,
                              input logic [15:0] n, input logic f);
    tok_t t;
    t.kind = k;
    t.ln = 16'(l);
    t.col = 16'(c);
    t.off = 32'(o);
    t.len = n;
    t.fin = f;
    return t;
  endfunction

  always_comb begin
    logic isd, isa, iss, isw, start;
    logic [LW-1:0] l1, c1;
    logic [OW-1:0] o1;
    logic [5:0] sk;
    tok_t pend;
    mode_t m;
    isd = ib_r >= 8'h30 && ib_r <= 8'h39;
    isa = (ib_r >= 8'h41 && ib_r <= 8'h5a) || (ib_r >= 8'h61 && ib_r <= 8'h7a);
    iss = ib_r == 8'h20 || (ib_r >= 8'd9 && ib_r <= 8'd13);
    isw = isa || isd || ib_r == 8'h5f;
    mode_nxt = mode_r; line_nxt = line_r; col_nxt = col_r; off_nxt = off_r;
    sline_nxt = sline_r; scol_nxt = scol_r; sstart_nxt = sstart_r;
    len_nxt = len_r; mask_nxt = mask_r;
    t0 = '0; t1 = '0; t2 = '0; nres = 2'd0;
    start = 1'b0;
    sk = K_UNK;
    pend = mk(K_UNK, sline_r, scol_r, sstart_r, len_r, 1'b0);
    // advance
    if (ib_r == 8'h0a) begin
      l1 = (line_r == LMAX) ? LMAX : line_r + LW'(1);
      c1 = LW'(1);
    end else begin
      l1 = line_r;
      c1 = (col_r == LMAX) ? LMAX : col_r + LW'(1);
    end
    o1 = (off_r == OMAX) ? OMAX : off_r + OW'(1);
    m = mode_r;
    if (icv_r) begin
      line_nxt = l1; col_nxt = c1; off_nxt = o1;
      unique case (mode_r)
        M_STR: begin
          if (ib_r == 8'h27) begin
            pend.kind = K_STRING; t0 = pend; nres = 2'd1; m = M_IDLE;
          end else if (len_r != 16'hffff) len_nxt = len_r + 16'd1;
        end
        M_INT: begin
          if (isd) begin
            if (len_r != 16'hffff) len_nxt = len_r + 16'd1;
          end else begin
            pend.kind = K_INT; t0 = pend; nres = 2'd1; start = 1'b1;
          end
        end
        M_WORD: begin
          if (isw) begin
            mask_nxt = km_out;
            if (len_r != 16'hffff) len_nxt = len_r + 16'd1;
          end else begin
            pend.kind = wkind; t0 = pend; nres = 2'd1; start = 1'b1;
          end
        end
        M_GT, M_LT: begin
          if (ib_r == 8'h3d) begin
            pend.kind = (mode_r == M_GT) ? K_GE : K_LE; pend.len = 16'd2;
            t0 = pend; nres = 2'd1; m = M_IDLE;
          end else begin
            pend.kind = (mode_r == M_GT) ? K_GT : K_LT; t0 = pend; nres = 2'd1;
            start = 1'b1;
          end
        end
        default: start = 1'b1;
      endcase
      if (start) begin
        m = M_IDLE;
        if (iss) begin
          // whitespace starts no token
          m = M_IDLE;
        end else if (ib_r == 8'h27) begin
          sline_nxt = line_r; scol_nxt = col_r; sstart_nxt = o1; len_nxt = 16'd0; m = M_STR;
        end else if (ib_r == 8'h2d || isd) begin
          sline_nxt = line_r; scol_nxt = col_r; sstart_nxt = off_r; len_nxt = 16'd1; m = M_INT;
        end else if (isa || ib_r == 8'h5f) begin
          sline_nxt = line_r; scol_nxt = col_r; sstart_nxt = off_r; len_nxt = 16'd1;
          mask_nxt = km_out; m = M_WORD;
        end else if (ib_r == 8'h3e || ib_r == 8'h3c) begin
          sline_nxt = line_r; scol_nxt = col_r; sstart_nxt = off_r; len_nxt = 16'd1;
          m = (ib_r == 8'h3e) ? M_GT : M_LT;
        end else begin
          unique case (ib_r)
            8'h2a: sk = K_STAR;
            8'h2e: sk = K_DOT;
            8'h2c: sk = K_COMMA;
            8'h28: sk = K_LPAR;
            8'h29: sk = K_RPAR;
            8'h3d: sk = K_EQ;
            default: sk = K_UNK;
          endcase
          if (nres == 2'd0) begin
            t0 = mk(sk, line_r, col_r, off_r, 16'd1, 1'b0);
          end else begin
            t1 = mk(sk, line_r, col_r, off_r, 16'd1, 1'b0);
          end
          nres = nres + 2'd1;
        end
      end
    end
    mode_nxt = m;
    if (ie_r) begin
      pend = mk(K_UNK, sline_nxt, scol_nxt, sstart_nxt, len_nxt, 1'b0);
      if (m != M_IDLE) begin
        unique case (m)
          M_STR: pend.kind = K_STRING;
          M_INT: pend.kind = K_INT;
          M_WORD: pend.kind = end_wkind;
          M_GT: pend.kind = K_GT;
          default: pend.kind = K_LT;
        endcase
        if (nres == 2'd0) t0 = pend; else t1 = pend;
        nres = nres + 2'd1;
      end
      unique case (nres)
        2'd0: t0 = mk(K_END, line_nxt, col_nxt, off_nxt, 16'd0, 1'b1);
        2'd1: t1 = mk(K_END, line_nxt, col_nxt, off_nxt, 16'd0, 1'b1);
        default: t2 = mk(K_END, line_nxt, col_nxt, off_nxt, 16'd0, 1'b1);
      endcase
      nres = nres + 2'd1;
      mode_nxt = M_IDLE; line_nxt = LW'(1); col_nxt = LW'(1); off_nxt = '0;
      sline_nxt = LW'(1); scol_nxt = LW'(1); sstart_nxt = '0; len_nxt = 16'd0;
      mask_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      mode_r <= M_IDLE; line_r <= LW'(1); col_r <= LW'(1); off_r <= '0;
      sline_r <= LW'(1); scol_r <= LW'(1); sstart_r <= '0; len_r <= 16'd0;
      mask_r <= '1; rd_r <= 2'd0; wr_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      if (go || !iv_r) iv_r <= take;
      if (go) begin
        mode_r <= mode_nxt; line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt;
        sline_r <= sline_nxt; scol_r <= scol_nxt; sstart_r <= sstart_nxt;
        len_r <= len_nxt; mask_r <= mask_nxt;
        wr_r <= wr_r + nres;
      end
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + (go ? {1'b0, nres} : 3'd0) - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ib_r <= in_char_byte; icv_r <= in_char_valid; ie_r <= in_text_end;
    end
    if (go) begin
      if (nres != 2'd0) fifo_r[wr_r] <= t0;
      if (nres >= 2'd2) fifo_r[wr_r + 2'd1] <= t1;
      if (nres == 2'd3) fifo_r[wr_r + 2'd2] <= t2;
    end
  end

  assign out_valid = cnt_r != 3'd0;
  assign out_token_kind = fifo_r[rd_r].kind;
  assign out_start_line = fifo_r[rd_r].ln;
  assign out_start_column = fifo_r[rd_r].col;
  assign out_text_offset = fifo_r[rd_r].off;
  assign out_text_length = fifo_r[rd_r].len;
  assign out_final_token = fifo_r[rd_r].fin;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("fifo overflow");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    go && ie_r |=> mode_r == M_IDLE && off_r == '0)
    else $error("end did not reset state");
  a_nres: assert property (@(posedge clk) disable iff (!rst_n)
    go && ie_r |-> nres != 2'd0)
    else $error("end produced no token");
endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench for query_text_tokenizer_top: directed and random query text with a
// behavioral lexer predicting every token, checked in order against the result port
// depends on qtt_pkg and the rtl of query_text_tokenizer_top
`default_nettype none
module testbench;
  import qtt_pkg::*;

  typedef struct {
    logic [5:0] kind;
    logic [15:0] ln;
    logic [15:0] col;
    logic [31:0] off;
    logic [15:0] len;
    logic fin;
  } token_t;

  localparam int WatchdogLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_char_valid, in_text_end;
  logic [7:0] in_char_byte;
  logic out_valid, out_ready;
  logic [5:0] out_token_kind;
  logic [15:0] out_start_line, out_start_column, out_text_length;
  logic [31:0] out_text_offset;
  logic out_final_token;

  query_text_tokenizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_char_byte(in_char_byte),
    .in_char_valid(in_char_valid), .in_text_end(in_text_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_token_kind(out_token_kind),
    .out_start_line(out_start_line), .out_start_column(out_start_column),
    .out_text_offset(out_text_offset), .out_text_length(out_text_length),
    .out_final_token(out_final_token)
  );

  // predictor state
  mode_t lx_mode;
  logic [15:0] lx_line, lx_col, lx_tok_line, lx_tok_col, lx_len;
  logic [31:0] lx_off, lx_tok_off;
  logic [25:0] lx_mask;

  token_t expected_tokens[$];
  int mismatches;
  int idle_cycles;
  bit hold_off;

  string kw_names[26] = '{"SELECT", "SUBSCRIBE", "FROM", "WHERE", "LIMIT", "AND", "BETWEEN",
    "AT", "SUM", "AVG", "MIN", "MAX", "VWAP", "SPREAD", "MID", "IMBALANCE",
    "DEPTH", "DEPTH", "CUMULATIVE", "price", "quantity", "order",
    "timestamp", "sequence", "side", "level"};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // keywords that carry an underscore are completed here
  task automatic complete_kw_names();
    kw_names[14] = {kw_names[14], "_PRICE"};
    kw_names[16] = {kw_names[16], "_RANGE"};
    kw_names[18] = {kw_names[18], "_VOLUME"};
    kw_names[21] = {kw_names[21], "_count"};
    kw_names[23] = {kw_names[23], "_number"};
  endtask

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction
  function automatic logic [31:0] inc32(logic [31:0] v);
    return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

  task automatic lexer_reset();
    lx_mode = M_IDLE; lx_line = 1; lx_col = 1; lx_off = 0;
    lx_tok_line = 1; lx_tok_col = 1; lx_tok_off = 0; lx_len = 0; lx_mask = '1;
  endtask

  task automatic push_token(logic [5:0] k, logic [15:0] l, logic [15:0] c, logic [31:0] o,
                            logic [15:0] n, logic f);
    token_t t;
    t.kind = k; t.ln = l; t.col = c; t.off = o; t.len = n; t.fin = f;
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic push_pending(logic [5:0] k);
    push_token(k, lx_tok_line, lx_tok_col, lx_tok_off, lx_len, 0);
  endtask

  task automatic step_position(logic [7:0] b);
    if (b == 8'h0A) begin
      lx_line = inc16(lx_line); lx_col = 1;
    end else lx_col = inc16(lx_col);
    lx_off = inc32(lx_off);
  endtask

  task automatic narrow_mask(logic [7:0] b);
    string s;
    for (int k = 0; k < 26; k++) begin
      s = kw_names[k];
      if (lx_mask[k] && (lx_len >= s.len() || to_lower(s[lx_len]) != to_lower(b)))
        lx_mask[k] = 0;
    end
  endtask

  function automatic logic [5:0] word_kind();
    string s;
    for (int k = 0; k < 26; k++) begin
      s = kw_names[k];
      if (lx_mask[k] && s.len() == lx_len) return 6'(k);
    end
    return K_UNK;
  endfunction

  task automatic begin_token(logic [7:0] b);
    logic [5:0] k;
    lx_mode = M_IDLE;
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      step_position(b);
    end else if (b == "'") begin
      lx_tok_line = lx_line; lx_tok_col = lx_col; lx_tok_off = inc32(lx_off);
      lx_len = 0; lx_mode = M_STR; step_position(b);
    end else if (b == "-" || is_dig(b)) begin
      lx_tok_line = lx_line; lx_tok_col = lx_col; lx_tok_off = lx_off;
      lx_len = 1; lx_mode = M_INT; step_position(b);
    end else if (is_alp(b) || b == "_") begin
      lx_tok_line = lx_line; lx_tok_col = lx_col; lx_tok_off = lx_off;
      lx_len = 0; lx_mask = '1; narrow_mask(b);
      lx_len = 1; lx_mode = M_WORD; step_position(b);
    end else if (b == ">" || b == "<") begin
      lx_tok_line = lx_line; lx_tok_col = lx_col; lx_tok_off = lx_off;
      lx_len = 1; lx_mode = (b == ">") ? M_GT : M_LT; step_position(b);
    end else begin
      case (b)
        "*": k = K_STAR;
        ".": k = K_DOT;
        ",": k = K_COMMA;
        "(": k = K_LPAR;
        ")": k = K_RPAR;
        "=": k = K_EQ;
        default: k = K_UNK;
      endcase
      push_token(k, lx_line, lx_col, lx_off, 1, 0);
      step_position(b);
    end
  endtask

  task automatic lex_char(logic [7:0] b);
    case (lx_mode)
      M_STR: begin
        if (b == "'") begin
          push_pending(K_STRING); lx_mode = M_IDLE;
        end else lx_len = inc16(lx_len);
        step_position(b);
        return;
      end
      M_INT: begin
        if (is_dig(b)) begin
          lx_len = inc16(lx_len); step_position(b); return;
        end
        push_pending(K_INT);
      end
      M_WORD: begin
        if (is_alp(b) || is_dig(b) || b == "_") begin
          narrow_mask(b); lx_len = inc16(lx_len); step_position(b); return;
        end
        push_pending(word_kind());
      end
      M_GT, M_LT: begin
        if (b == "=") begin
          lx_len = 2; push_pending(lx_mode == M_GT ? K_GE : K_LE);
          lx_mode = M_IDLE; step_position(b); return;
        end
        push_pending(lx_mode == M_GT ? K_GT : K_LT);
      end
      default: ;
    endcase
    begin_token(b);
  endtask

  task automatic predict_tokens(logic [7:0] b, logic cv, logic te);
    if (cv) lex_char(b);
    if (te) begin
      case (lx_mode)
        M_STR: push_pending(K_STRING);
        M_INT: push_pending(K_INT);
        M_WORD: push_pending(word_kind());
        M_GT: push_pending(K_GT);
        M_LT: push_pending(K_LT);
        default: ;
      endcase
      push_token(K_END, lx_line, lx_col, lx_off, 0, 1);
      lexer_reset();
    end
  endtask

  // one transfer on the input channel
  task automatic send_item(logic [7:0] b, logic cv, logic te);
    in_valid <= 1; in_char_byte <= b; in_char_valid <= cv; in_text_end <= te;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(b, cv, te);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1, close && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_keywords();
    send_text("SELECT sum(x) FROM t WHERE a>=-1 ", 0);
    send_text("aNd b<='p\nq' 7.5*vwap_ < 'o", 1);
  endtask

  task automatic test_edges();
    send_item(8'h00, 1, 0);
    send_item(8'hFF, 1, 0);
    send_item(8'h80, 1, 0);
    send_item(8'h7F, 0, 0);
    send_item("-", 1, 0);
    send_item(" ", 1, 0);
    send_item(">", 1, 1);
    send_item("<", 1, 0);
    send_item(8'h55, 0, 1);
    send_item(8'hAA, 0, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    send_text("vwap(mid)>=spread,at", 0);
    hold_off = 0;
    send_item(8'h00, 0, 1);
    wait_drained();
  endtask

  function automatic logic [7:0] random_byte();
    string pool;
    pool = "SELECTFROMWHEREsubscribe_price 0123456789-'<>=*.,()\n\t";
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic test_random();
    string w;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        w = kw_names[$urandom_range(0, 25)];
        send_text(w, 0);
        send_item(" ", 1, 0);
      end else begin
        send_item(random_byte(), $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
      end
      if ($urandom_range(0, 30) == 0) wait_drained();
    end
    send_item(8'h00, 0, 1);
  endtask

  // receiver stalls, with one long hold-off each time it is requested
  initial begin
    bit held;
    held = 0;
    out_ready <= 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off) held = 0;
      if (hold_off && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (60) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 3) != 0) || (idle_cycles > 200);
    end
  end

  always @(posedge clk) begin
    token_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token kind %0d", out_token_kind);
      end else begin
        e = expected_tokens.pop_front();
        if (out_token_kind !== e.kind || out_start_line !== e.ln
            || out_start_column !== e.col || out_text_offset !== e.off
            || out_text_length !== e.len || out_final_token !== e.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d l%0d c%0d o%0d n%0d f%0d got k%0d l%0d c%0d o%0d n%0d f%0d",
              e.kind, e.ln, e.col, e.off, e.len, e.fin, out_token_kind, out_start_line,
              out_start_column, out_text_offset, out_text_length, out_final_token);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WatchdogLimit) @(posedge clk);
    $display("query_text_tokenizer_top verification failed");
    $finish;
  end

  initial begin
    rst_n <= 0; in_valid <= 0; in_char_byte <= 0; in_char_valid <= 0; in_text_end <= 0;
    mismatches = 0; hold_off = 0;
    complete_kw_names();
    lexer_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_keywords();
    test_edges();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0)
      $display("query_text_tokenizer_top verification clean");
    else
      $display("query_text_tokenizer_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire
